>>> rtl/utf8_thai_ascii_char_filter_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef UTF8_THAI_ASCII_CHAR_FILTER_MACROS_SVH
`define UTF8_THAI_ASCII_CHAR_FILTER_MACROS_SVH

// property checked outside reset
`define UTAF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define UTAF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/utaf_pkg.sv
// shared types, constants and byte classification for the utf8 thai/ascii filter
// no dependencies
package utaf_pkg;

    localparam int unsigned CMDQ_DEPTH = 4;
    localparam logic [15:0] CAP_RESET  = 16'd512;

    localparam logic [7:0] THAI_SECOND_A = 8'hB8;
    localparam logic [7:0] THAI_SECOND_B = 8'hB9;
    localparam logic [3:0] LEAD3_HI      = 4'hE;
    localparam logic [3:0] LEAD4_HI      = 4'hF;
    localparam logic [1:0] LEAD2_HI      = 2'b11;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_LEAD   = 4'b0010,
        PH_SECOND = 4'b0100,
        PH_SKIP   = 4'b1000
    } t_phase;

    // one queue entry: up to three kept bytes, then optionally the terminator
    typedef struct packed {
        logic [1:0] n_bytes;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       is_end;
    } t_cmd;

    function automatic logic ascii_passes(input logic [7:0] b);
        logic ok;
        ok = 1'b0;
        if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
            (b >= 8'h30 && b <= 8'h39)) begin
            ok = 1'b1;
        end
        case (b)
            8'h20, 8'h2E, 8'h2C, 8'h27, 8'h22, 8'h21, 8'h3F, 8'h40, 8'h23,
            8'h25, 8'h26, 8'h2A, 8'h5E, 8'h2D, 8'h5F, 8'h2B, 8'h3D, 8'h28,
            8'h29, 8'h3A, 8'h3B: ok = 1'b1;
            default: ;
        endcase
        return ok;
    endfunction

endpackage

>>> rtl/utaf_front.sv
// front end: accepts input bytes, tracks character state and output budget,
// turns kept bytes and string ends into queue entries. depends on utaf_pkg
module utaf_front import utaf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_accept,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last,
    output logic        o_cmd_push,
    output t_cmd        o_cmd
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_lead, n_lead;
    logic [7:0]  r_second, n_second;
    logic [1:0]  r_skip, n_skip;
    logic [15:0] r_count, n_count;
    logic        r_stopped, n_stopped;
    logic [15:0] r_cap;
    logic [16:0] cnt_ext;
    logic [16:0] cap_ext;
    t_cmd        cmd;

    assign cnt_ext = {1'b0, r_count};
    assign cap_ext = {1'b0, r_cap};

    always_comb begin
        n_phase   = r_phase;
        n_lead    = r_lead;
        n_second  = r_second;
        n_skip    = r_skip;
        n_count   = r_count;
        n_stopped = r_stopped;
        cmd       = '0;
        if (i_accept) begin
            if (!r_stopped) begin
                case (r_phase)
                    PH_IDLE: begin
                        if (cnt_ext + 17'd1 >= cap_ext) begin
                            n_stopped = 1'b1;
                        end else if (ascii_passes(i_in_byte)) begin
                            cmd.n_bytes = 2'd1;
                            cmd.b0      = i_in_byte;
                            n_count     = r_count + 16'd1;
                        end else if (i_in_byte[7:4] == LEAD3_HI) begin
                            n_lead  = i_in_byte;
                            n_phase = PH_LEAD;
                        end else if (i_in_byte[7:4] == LEAD4_HI) begin
                            n_skip  = 2'd3;
                            n_phase = PH_SKIP;
                        end else if (i_in_byte[7:6] == LEAD2_HI) begin
                            n_skip  = 2'd1;
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_LEAD: begin
                        if (i_in_byte == THAI_SECOND_A || i_in_byte == THAI_SECOND_B) begin
                            n_second = i_in_byte;
                            n_phase  = PH_SECOND;
                        end else begin
                            n_skip  = 2'd1;
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_SECOND: begin
                        // three bytes plus the terminator must fit
                        if (cnt_ext + 17'd3 < cap_ext) begin
                            cmd.n_bytes = 2'd3;
                            cmd.b0      = r_lead;
                            cmd.b1      = r_second;
                            cmd.b2      = i_in_byte;
                            n_count     = r_count + 16'd3;
                        end else begin
                            n_stopped = 1'b1;
                        end
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        if (r_skip <= 2'd1) begin
                            n_skip  = 2'd0;
                            n_phase = PH_IDLE;
                        end else begin
                            n_skip = r_skip - 2'd1;
                        end
                    end
                endcase
            end
            if (i_last) begin
                cmd.is_end = 1'b1;
                n_phase    = PH_IDLE;
                n_lead     = '0;
                n_second   = '0;
                n_skip     = '0;
                n_count    = '0;
                n_stopped  = 1'b0;
            end
        end
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = i_accept && (cmd.n_bytes != 2'd0 || cmd.is_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_lead    <= '0;
            r_second  <= '0;
            r_skip    <= '0;
            r_count   <= '0;
            r_stopped <= 1'b0;
            r_cap     <= CAP_RESET;
        end else begin
            r_phase   <= n_phase;
            r_lead    <= n_lead;
            r_second  <= n_second;
            r_skip    <= n_skip;
            r_count   <= n_count;
            r_stopped <= n_stopped;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

endmodule

>>> rtl/utaf_cmdq.sv
// small fifo of entries between front end and back end
// depends on utaf_pkg
module utaf_cmdq import utaf_pkg::*; #(
    parameter int unsigned DEPTH = CMDQ_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

>>> rtl/utaf_back.sv
// back end: unpacks queue entries into single results through an output register
// depends on utaf_pkg
module utaf_back import utaf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  logic       i_head_empty,
    output logic       o_head_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_byte,
    output logic       o_is_end
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic [1:0] r_pos, n_pos;
    logic       load;
    logic [2:0] total;
    logic       last_piece;
    logic [7:0] piece_byte;
    logic       piece_end;

    assign total      = {1'b0, i_head.n_bytes} + {2'b00, i_head.is_end};
    assign last_piece = ({1'b0, r_pos} == total - 3'd1);
    assign load       = !i_head_empty && (!r_valid || i_pop);
    assign o_head_pop = load && last_piece;

    // pieces past the byte count are the terminator
    always_comb begin
        piece_end = 1'b0;
        case (r_pos)
            2'd0:    piece_byte = i_head.b0;
            2'd1:    piece_byte = i_head.b1;
            2'd2:    piece_byte = i_head.b2;
            default: piece_byte = '0;
        endcase
        if (r_pos >= i_head.n_bytes) begin
            piece_byte = '0;
            piece_end  = 1'b1;
        end
        n_pos = last_piece ? 2'd0 : r_pos + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= piece_byte;
            r_end  <= piece_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_pos   <= n_pos;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    assign o_empty    = !r_valid;
    assign o_out_byte = r_byte;
    assign o_is_end   = r_end;

endmodule

>>> rtl/utf8_thai_ascii_char_filter.sv
// top level of the utf8 thai/ascii byte filter
// depends on utaf_pkg, utaf_front, utaf_cmdq, utaf_back
//
//  channel   handshake          payload
//  input     push / full        i_in_byte[7:0], i_last
//  result    empty / pop        o_out_byte[7:0], o_is_end
//  config    i_cfg_we           i_cfg_wdata[15:0] (capacity)
//
// one input byte per cycle while the entry queue has room; an accepted byte passes
// through the entry queue and then the output register.
// a thai character with the terminator yields four results; the back end drains
// one per cycle while the receiver pops, so bursts fill the queue and raise full.
// synchronous active-low reset clears control state, capacity returns to 512.
module utf8_thai_ascii_char_filter import utaf_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = CMDQ_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_is_end
);

    logic accept;
    logic cmd_push;
    t_cmd cmd;
    t_cmd head;
    logic head_empty;
    logic head_pop;

    assign accept = push && !full;

    utaf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .i_last      (i_last),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd)
    );

    utaf_cmdq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd),
        .i_pop   (head_pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (head_empty)
    );

    utaf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_empty (head_empty),
        .o_head_pop   (head_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_out_byte   (o_out_byte),
        .o_is_end     (o_is_end)
    );

endmodule

>>> rtl/utaf_checker.sv
// port-level checks for the utf8 thai/ascii filter, bound to the top level
// depends on utf8_thai_ascii_char_filter_macros.svh
`include "utf8_thai_ascii_char_filter_macros.svh"
module utaf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_is_end
);

    `UTAF_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> empty, "result side not empty after reset")
    `UTAF_ASSERT_ALWAYS(a_rst_full, i_clk, !i_rst_n |=> !full, "input side full after reset")
    `UTAF_ASSERT(a_end_zero, i_clk, i_rst_n, (!empty && o_is_end) |-> (o_out_byte == 8'd0), "terminator carries a nonzero byte")
    `UTAF_ASSERT(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_is_end)), "waiting result changed")

endmodule

bind utf8_thai_ascii_char_filter utaf_checker u_utaf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_byte (o_out_byte),
    .o_is_end   (o_is_end)
);

>>> verif/testbench.sv
// self-checking testbench for utf8_thai_ascii_char_filter: directed byte table, then random strings
// checks every result transaction against the bench filter model or the directed table's typed-in result
// depends on utaf_pkg and the filter rtl
module testbench;
    import utaf_pkg::*;

    localparam int TOTAL_ITEMS  = 430;
    localparam int DRAIN_CYCLES = 12;
    localparam int TAIL_CYCLES  = 24;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 40;
    localparam int N_DIRECTED   = 34;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_res;

    // how a table row is checked: by the bench model or by the typed-in result
    typedef enum {CHK_PRED, CHK_NONE, CHK_SAME, CHK_END, CHK_SAME_END} t_row_chk;

    typedef struct {
        logic [7:0] b;
        logic       last;
        int         cap;    // nonzero: capacity written before this byte
        t_row_chk   chk;
    } t_row;

    typedef enum {DRAIN_FREE, DRAIN_HALF, DRAIN_SLOW, DRAIN_PERIODIC} t_drain;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        push;
    logic        full;
    logic [7:0]  i_in_byte;
    logic        i_last;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic        o_is_end;

    utf8_thai_ascii_char_filter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_in_byte   (i_in_byte),
        .i_last      (i_last),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte),
        .o_is_end    (o_is_end)
    );

    // filter model state
    logic [15:0] cap_reg;
    t_phase      fp_phase;
    logic [7:0]  fp_lead;
    logic [7:0]  fp_second;
    logic [1:0]  fp_skip;
    logic [15:0] fp_count;
    logic        fp_halted;

    t_res       expected_out [$];
    logic [7:0] text_q [$];
    int         mismatches    = 0;
    int         items_sent    = 0;
    int         burst_left    = 0;
    int         cycle_count   = 0;
    int         hold_reqs     = 0;

    t_row dir_rows [N_DIRECTED] = '{
        '{8'h41, 1'b0, 0,     CHK_SAME},
        '{8'h39, 1'b0, 0,     CHK_SAME},
        '{8'h20, 1'b0, 0,     CHK_SAME},
        '{8'h01, 1'b0, 0,     CHK_NONE},
        '{8'hE0, 1'b0, 0,     CHK_NONE},
        '{8'hB8, 1'b0, 0,     CHK_NONE},
        '{8'h81, 1'b0, 0,     CHK_PRED},
        '{8'hEF, 1'b0, 0,     CHK_NONE},
        '{8'hB9, 1'b0, 0,     CHK_NONE},
        '{8'hFF, 1'b0, 0,     CHK_PRED},
        '{8'hE5, 1'b0, 0,     CHK_NONE},
        '{8'h80, 1'b0, 0,     CHK_NONE},
        '{8'h41, 1'b0, 0,     CHK_NONE},
        '{8'hF7, 1'b0, 0,     CHK_NONE},
        '{8'h90, 1'b0, 0,     CHK_NONE},
        '{8'h90, 1'b0, 0,     CHK_NONE},
        '{8'h90, 1'b0, 0,     CHK_NONE},
        '{8'hC3, 1'b0, 0,     CHK_NONE},
        '{8'h80, 1'b0, 0,     CHK_NONE},
        '{8'hBF, 1'b0, 0,     CHK_NONE},
        '{8'hE0, 1'b1, 0,     CHK_END},
        '{8'h78, 1'b0, 2,     CHK_SAME},
        '{8'h79, 1'b0, 0,     CHK_NONE},
        '{8'h7A, 1'b1, 0,     CHK_END},
        '{8'hE0, 1'b0, 4,     CHK_NONE},
        '{8'hB8, 1'b0, 0,     CHK_NONE},
        '{8'h82, 1'b0, 0,     CHK_PRED},
        '{8'h61, 1'b1, 0,     CHK_END},
        '{8'h51, 1'b0, 65535, CHK_SAME},
        '{8'hE0, 1'b0, 3,     CHK_NONE},
        '{8'hB8, 1'b0, 0,     CHK_NONE},
        '{8'h82, 1'b0, 0,     CHK_NONE},
        '{8'h21, 1'b1, 0,     CHK_END},
        '{8'h3B, 1'b1, 0,     CHK_SAME_END}
    };

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic ascii_kept(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9") ||
               (b inside {" ", ".", ",", "'", "\"", "!", "?", "@", "#", "%", "&", "*",
                          "^", "-", "_", "+", "=", "(", ")", ":", ";"});
    endfunction

    function automatic void clear_string();
        fp_phase  = PH_IDLE;
        fp_lead   = 8'h00;
        fp_second = 8'h00;
        fp_skip   = 2'd0;
        fp_count  = 16'd0;
        fp_halted = 1'b0;
    endfunction

    // results one accepted byte causes
    function automatic void filter_step(input logic [7:0] b, input logic l,
                                        output t_res res [4], output int n);
        int cnt;
        int cap;
        cnt = int'(fp_count);
        cap = int'(cap_reg);
        n = 0;
        if (!fp_halted) begin
            case (fp_phase)
                PH_IDLE: begin
                    if (cnt + 1 >= cap) begin
                        fp_halted = 1'b1;
                    end else if (ascii_kept(b)) begin
                        res[n] = '{data: b, fin: 1'b0};
                        n++;
                        fp_count = fp_count + 16'd1;
                    end else if (b[7:4] == LEAD3_HI) begin
                        fp_lead  = b;
                        fp_phase = PH_LEAD;
                    end else if (b[7:4] == LEAD4_HI) begin
                        fp_skip  = 2'd3;
                        fp_phase = PH_SKIP;
                    end else if (b[7:6] == LEAD2_HI) begin
                        fp_skip  = 2'd1;
                        fp_phase = PH_SKIP;
                    end
                end
                PH_LEAD: begin
                    if (b == THAI_SECOND_A || b == THAI_SECOND_B) begin
                        fp_second = b;
                        fp_phase  = PH_SECOND;
                    end else begin
                        // lead was a non-thai three byte char, one byte still to drop
                        fp_skip  = 2'd1;
                        fp_phase = PH_SKIP;
                    end
                end
                PH_SECOND: begin
                    if (cnt + 3 < cap) begin
                        res[0] = '{data: fp_lead, fin: 1'b0};
                        res[1] = '{data: fp_second, fin: 1'b0};
                        res[2] = '{data: b, fin: 1'b0};
                        n = 3;
                        fp_count = fp_count + 16'd3;
                    end else begin
                        fp_halted = 1'b1;
                    end
                    fp_phase = PH_IDLE;
                end
                default: begin
                    if (fp_skip != 2'd0) fp_skip = fp_skip - 2'd1;
                    if (fp_skip == 2'd0) fp_phase = PH_IDLE;
                end
            endcase
        end
        if (l) begin
            res[n] = '{data: 8'h00, fin: 1'b1};
            n++;
            clear_string();
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        mismatches++;
    endtask

    // offer one byte, hold it until accepted, then maybe idle for a gap
    task automatic send_byte(input logic [7:0] b, input logic l,
                             output t_res res [4], output int n);
        int gap;
        push      <= 1'b1;
        i_in_byte <= b;
        i_last    <= l;
        do @(posedge i_clk); while (full);
        filter_step(b, l, res, n);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
            gap = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // capacity is only written once every pending result has drained
    task automatic write_capacity(input logic [15:0] v);
        push <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cap_reg = v;
    endtask

    function automatic logic [15:0] pick_capacity();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 16'd2;
            1:       return 16'hFFFF;
            2:       return 16'd512;
            8, 9:    return 16'($urandom_range(2, 65535));
            default: return 16'($urandom_range(3, 48));
        endcase
    endfunction

    function automatic void add_char();
        int    r;
        int    k;
        string punct;
        punct = "!#%&()*+-=:;?@^_ .,'\"";
        r = $urandom_range(0, 99);
        if (r < 40) begin
            case ($urandom_range(0, 3))
                0:       text_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
                1:       text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
                2:       text_q.push_back(8'($urandom_range(8'h30, 8'h39)));
                default: text_q.push_back(8'(punct[$urandom_range(0, 20)]));
            endcase
        end else if (r < 65) begin
            // thai: lead 0xe0-0xef, second 0xb8/0xb9, third mostly a continuation
            text_q.push_back({LEAD3_HI, 4'($urandom_range(0, 15))});
            text_q.push_back($urandom_range(0, 1) ? THAI_SECOND_B : THAI_SECOND_A);
            text_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                          : 8'($urandom_range(8'h80, 8'hBF)));
        end else if (r < 73) begin
            text_q.push_back(8'($urandom_range(1, 8'h7F)));
        end else if (r < 81) begin
            text_q.push_back({LEAD3_HI, 4'($urandom_range(0, 15))});
            text_q.push_back(8'($urandom_range(1, 255)));
            text_q.push_back(8'($urandom_range(1, 255)));
        end else if (r < 87) begin
            text_q.push_back({LEAD4_HI, 4'($urandom_range(0, 15))});
            for (k = 0; k < 3; k++) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (r < 93) begin
            text_q.push_back({LEAD2_HI, 6'($urandom_range(0, 31))});
            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else begin
            text_q.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    function automatic void build_text(input bit force_long);
        int nchars;
        int keep;
        text_q.delete();
        if (force_long) nchars = 48;
        else if ($urandom_range(0, 9) == 0) nchars = $urandom_range(20, 50);
        else nchars = $urandom_range(1, 10);
        repeat (nchars) add_char();
        // occasionally cut the string short, possibly inside a character
        if (!force_long && $urandom_range(0, 7) == 0) begin
            keep = $urandom_range(1, text_q.size());
            while (text_q.size() > keep) void'(text_q.pop_back());
        end
    endfunction

    // result side: stalls follow a changing pattern, plus long hold-offs on request
    initial begin
        t_drain mode;
        int     seg_left;
        int     hold_left;
        int     tick;
        int     holds_done;
        mode       = DRAIN_FREE;
        seg_left   = 0;
        hold_left  = 0;
        tick       = 0;
        holds_done = 0;
        pop        = 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_reqs != holds_done) begin
                hold_left  = LONG_HOLD;
                holds_done = hold_reqs;
            end
            if (seg_left == 0) begin
                mode     = t_drain'($urandom_range(0, 3));
                seg_left = $urandom_range(20, 80);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (mode)
                    DRAIN_FREE: pop <= 1'b1;
                    DRAIN_HALF: pop <= 1'($urandom_range(0, 1));
                    DRAIN_SLOW: pop <= ($urandom_range(0, 3) == 0);
                    default:    pop <= (tick % 5 >= 2);
                endcase
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (expected_out.size() == 0) begin
                report_mismatch("result with nothing pending", {o_is_end, o_out_byte}, 0);
            end else begin
                want = expected_out.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch("out_byte", o_out_byte, want.data);
                if (o_is_end !== want.fin)
                    report_mismatch("is_end", o_is_end, want.fin);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_res res [4];
        int   n;
        int   k;
        bit   first;
        bit   second_hold;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 16'd0;
        push        = 1'b0;
        i_in_byte   = 8'h00;
        i_last      = 1'b0;
        cap_reg     = CAP_RESET;
        clear_string();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (dir_rows[i].cap != 0) write_capacity(dir_rows[i].cap[15:0]);
            send_byte(dir_rows[i].b, dir_rows[i].last, res, n);
            case (dir_rows[i].chk)
                CHK_PRED: for (k = 0; k < n; k++) expected_out.push_back(res[k]);
                CHK_SAME: expected_out.push_back('{data: dir_rows[i].b, fin: 1'b0});
                CHK_END:  expected_out.push_back('{data: 8'h00, fin: 1'b1});
                CHK_SAME_END: begin
                    expected_out.push_back('{data: dir_rows[i].b, fin: 1'b0});
                    expected_out.push_back('{data: 8'h00, fin: 1'b1});
                end
                default: ;
            endcase
        end

        // first random string is long with room to spare, sent while the receiver holds off
        write_capacity(16'hFFFF);
        hold_reqs++;
        first         = 1'b1;
        second_hold   = 1'b0;
        while (items_sent < TOTAL_ITEMS) begin
            if (!first && $urandom_range(0, 4) == 0) write_capacity(pick_capacity());
            if (!second_hold && items_sent > TOTAL_ITEMS / 2) begin
                hold_reqs++;
                second_hold   = 1'b1;
            end
            build_text(first);
            first = 1'b0;
            for (int j = 0; j < text_q.size(); j++) begin
                send_byte(text_q[j], j == text_q.size() - 1, res, n);
                for (k = 0; k < n; k++) expected_out.push_back(res[k]);
            end
        end

        push <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
